// ----- src/irpdt_pkg.sv -----
package irpdt_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_IDX_W = $clog2(WORD_W);
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE   = 3'd4;

  localparam logic [TICK_W-1:0] RST_START_MARK  = 10'd642;
  localparam logic [TICK_W-1:0] RST_START_SPACE = 10'd321;
  localparam logic [TICK_W-1:0] RST_BIT_MARK    = 10'd40;
  localparam logic [TICK_W-1:0] RST_ZERO_SPACE  = 10'd40;
  localparam logic [TICK_W-1:0] RST_ONE_SPACE   = 10'd121;

  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_START_MARK  = 7'b0000010,
    PH_START_SPACE = 7'b0000100,
    PH_BIT_MARK    = 7'b0001000,
    PH_BIT_SPACE   = 7'b0010000,
    PH_STOP_MARK   = 7'b0100000,
    PH_STOP_SPACE  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_mark;
    logic [TICK_W-1:0] start_space;
    logic [TICK_W-1:0] bit_mark;
    logic [TICK_W-1:0] zero_space;
    logic [TICK_W-1:0] one_space;
  } cfg_t;

  typedef struct packed {
    logic              is_send;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- src/ir_pulse_distance_transmitter_unit.sv -----
// IR pulse-distance frame sender driven by carrier half-period ticks.
// Input channel (in_valid / in_stall): each word is either a tick
// (in_req_type 0) or a send request (in_req_type 1) carrying
// in_command_word, sent MSB first over BIT_COUNT bits.
// Result channel (out_valid / out_stall): exactly one word per input word,
// in order, giving the pin level, busy flag, frame-done strobe and the
// dropped-send flag after that input word has been applied.
// Config channel (cfg_valid / cfg_ready, cfg_ready always high): writes the
// five 10-bit tick counts by index; write only while the block is idle.
// A result passes through the input register, a two-entry queue and the
// output register.
// Throughput: one word per cycle while the receiver does not stall; the frame
// engine updates its counter and phase once per word.
// When the receiver stalls the output register holds its word, the queue
// fills, and in_stall rises once the input register cannot drain.
// Synchronous reset clears the queue, the engine (idle, pin low) and loads
// the tick-count defaults; no word is in flight after reset.
module ir_pulse_distance_transmitter_unit #(
  parameter int unsigned BIT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_command_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ir_level,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic        out_send_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  irpdt_pkg::cfg_t      cfg_r;
  irpdt_pkg::q_status_t q_status;
  irpdt_pkg::item_t     push_item;
  irpdt_pkg::item_t     pop_item;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mark  <= irpdt_pkg::RST_START_MARK;
      cfg_r.start_space <= irpdt_pkg::RST_START_SPACE;
      cfg_r.bit_mark    <= irpdt_pkg::RST_BIT_MARK;
      cfg_r.zero_space  <= irpdt_pkg::RST_ZERO_SPACE;
      cfg_r.one_space   <= irpdt_pkg::RST_ONE_SPACE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irpdt_pkg::CFG_START_MARK:  cfg_r.start_mark  <= cfg_data;
        irpdt_pkg::CFG_START_SPACE: cfg_r.start_space <= cfg_data;
        irpdt_pkg::CFG_BIT_MARK:    cfg_r.bit_mark    <= cfg_data;
        irpdt_pkg::CFG_ZERO_SPACE:  cfg_r.zero_space  <= cfg_data;
        irpdt_pkg::CFG_ONE_SPACE:   cfg_r.one_space   <= cfg_data;
        default: ;
      endcase
    end
  end

  irpdt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_command_word (in_command_word),
    .q_status        (q_status),
    .push            (push),
    .push_item       (push_item)
  );

  irpdt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  irpdt_back #(
    .BIT_COUNT (BIT_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_status         (q_status),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ir_level     (out_ir_level),
    .out_busy_res     (out_busy_res),
    .out_frame_done   (out_frame_done),
    .out_send_dropped (out_send_dropped)
  );

endmodule

// ----- src/irpdt_front.sv -----
module irpdt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [31:0]         in_command_word,
  input  irpdt_pkg::q_status_t q_status,
  output logic                push,
  output irpdt_pkg::item_t    push_item
);

  logic             valid_r;
  logic             valid_nxt;
  irpdt_pkg::item_t item_r;
  logic             take;

  assign push     = valid_r & ~q_status.full;
  assign in_stall = valid_r & q_status.full;
  assign take     = in_valid & ~in_stall;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // tick items carry no command bits
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.is_send <= in_req_type;
      item_r.word    <= in_req_type ? in_command_word : '0;
    end
  end

endmodule

// ----- src/irpdt_queue.sv -----
module irpdt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  irpdt_pkg::item_t     push_item,
  input  logic                 pop,
  output irpdt_pkg::item_t     pop_item,
  output irpdt_pkg::q_status_t q_status
);

  irpdt_pkg::item_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);
  assign pop_item       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/irpdt_back.sv -----
module irpdt_back #(
  parameter int unsigned BIT_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  irpdt_pkg::cfg_t      cfg,
  input  irpdt_pkg::q_status_t q_status,
  input  irpdt_pkg::item_t     pop_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ir_level,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_send_dropped
);

  localparam int unsigned BL_W = $clog2(BIT_COUNT + 1);

  irpdt_pkg::phase_t              phase_r, phase_nxt;
  logic [irpdt_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [irpdt_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [BL_W-1:0]                bits_r, bits_nxt, bits_after;
  logic                           pin_r, pin_nxt;
  logic                           done, dropped;
  logic                           out_valid_r;
  logic                           ir_level_r, busy_r, frame_done_r, dropped_r;

  logic [BL_W-1:0]                idx;
  logic [31:0]                    idx_ext;
  logic                           cur_bit;
  logic [irpdt_pkg::TICK_W-1:0]   limit;
  logic [irpdt_pkg::TICK_W:0]     tick_inc;
  logic                           cnt_done;

  assign pop = ~q_status.empty & (~out_valid_r | ~out_stall);

  assign idx      = bits_r - BL_W'(1);
  assign idx_ext  = 32'(idx);
  assign cur_bit  = (bits_r != '0) && (idx_ext < irpdt_pkg::WORD_W)
                    && word_r[idx_ext[irpdt_pkg::WORD_IDX_W-1:0]];
  assign tick_inc = {1'b0, tick_r} + 11'd1;
  assign cnt_done = (tick_inc >= {1'b0, limit});
  assign bits_after = (bits_r != '0) ? idx : bits_r;

  always_comb begin
    unique case (phase_r)
      irpdt_pkg::PH_START_MARK:  limit = cfg.start_mark;
      irpdt_pkg::PH_START_SPACE: limit = cfg.start_space;
      irpdt_pkg::PH_BIT_MARK:    limit = cfg.bit_mark;
      irpdt_pkg::PH_BIT_SPACE:   limit = cur_bit ? cfg.one_space : cfg.zero_space;
      irpdt_pkg::PH_STOP_MARK:   limit = cfg.bit_mark;
      default:                   limit = cfg.zero_space;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    word_nxt  = word_r;
    bits_nxt  = bits_r;
    pin_nxt   = pin_r;
    done      = 1'b0;
    dropped   = 1'b0;
    if (pop_item.is_send) begin
      if (phase_r != irpdt_pkg::PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        word_nxt  = pop_item.word;
        bits_nxt  = BL_W'(BIT_COUNT);
        tick_nxt  = '0;
        pin_nxt   = 1'b0;
        phase_nxt = irpdt_pkg::PH_START_MARK;
      end
    end else begin
      if (phase_r != irpdt_pkg::PH_IDLE) begin
        tick_nxt = cnt_done ? '0 : tick_inc[irpdt_pkg::TICK_W-1:0];
      end
      unique case (phase_r)
        irpdt_pkg::PH_START_MARK: begin
          pin_nxt = cnt_done ? 1'b0 : ~pin_r;
          if (cnt_done) phase_nxt = irpdt_pkg::PH_START_SPACE;
        end
        irpdt_pkg::PH_START_SPACE: begin
          if (cnt_done) begin
            phase_nxt = (bits_r == '0) ? irpdt_pkg::PH_STOP_MARK : irpdt_pkg::PH_BIT_MARK;
          end
        end
        irpdt_pkg::PH_BIT_MARK: begin
          pin_nxt = cnt_done ? 1'b0 : ~pin_r;
          if (cnt_done) phase_nxt = irpdt_pkg::PH_BIT_SPACE;
        end
        irpdt_pkg::PH_BIT_SPACE: begin
          if (cnt_done) begin
            bits_nxt  = bits_after;
            phase_nxt = (bits_after == '0) ? irpdt_pkg::PH_STOP_MARK : irpdt_pkg::PH_BIT_MARK;
          end
        end
        irpdt_pkg::PH_STOP_MARK: begin
          pin_nxt = cnt_done ? 1'b0 : ~pin_r;
          if (cnt_done) phase_nxt = irpdt_pkg::PH_STOP_SPACE;
        end
        irpdt_pkg::PH_STOP_SPACE: begin
          if (cnt_done) begin
            phase_nxt = irpdt_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        default: begin
          phase_nxt = irpdt_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= irpdt_pkg::PH_IDLE;
      tick_r      <= '0;
      word_r      <= '0;
      bits_r      <= '0;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        word_r  <= word_nxt;
        bits_r  <= bits_nxt;
        pin_r   <= pin_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ir_level_r   <= pin_nxt;
      busy_r       <= (phase_nxt != irpdt_pkg::PH_IDLE);
      frame_done_r <= done;
      dropped_r    <= dropped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ir_level     = ir_level_r;
  assign out_busy_res     = busy_r;
  assign out_frame_done   = frame_done_r;
  assign out_send_dropped = dropped_r;

endmodule

// ----- src/irpdt_checker.sv -----
module irpdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ir_level,
  input logic        out_busy_res,
  input logic        out_frame_done,
  input logic        out_send_dropped
);

  // frame end reports the block already idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res)
    else $error("frame done while busy");

  // a dropped send only happens mid-frame, never on the closing tick
  a_drop_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_dropped |-> !out_frame_done && out_busy_res)
    else $error("dropped send outside a frame");

  // the pin rests low whenever no frame is running
  a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_ir_level)
    else $error("pin high while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ir_level)
      && $stable(out_busy_res) && $stable(out_frame_done) && $stable(out_send_dropped))
    else $error("stalled result word changed");

endmodule

bind ir_pulse_distance_transmitter_unit irpdt_checker u_irpdt_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TICK_W    = irpdt_pkg::TICK_W;
  localparam int unsigned CFG_IDX_W = irpdt_pkg::CFG_IDX_W;

  localparam int FRAME_BITS     = 32;
  localparam int RANDOM_ITEMS   = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [TICK_W-1:0]    TICKS_MAX  = 10'd1023;
  localparam logic [TICK_W-1:0]    TICKS_MIN  = 10'd1;

  typedef struct packed {
    logic ir_level;
    logic busy;
    logic done;
    logic dropped;
  } ir_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [31:0] in_command_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ir_level;
  logic        out_busy_res;
  logic        out_frame_done;
  logic        out_send_dropped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  // sender model of the frame engine
  irpdt_pkg::cfg_t   tx_cfg;
  irpdt_pkg::phase_t tx_phase;
  logic [TICK_W-1:0] tx_ticks;
  logic [31:0]       tx_shift;
  logic [6:0]        tx_bits_left;
  logic              tx_pin;

  irpdt_pkg::item_t pending_words[$];
  ir_result_t       expected_results[$];

  int queued_count = 0;
  int results_seen = 0;
  int frames_done  = 0;
  int drops_seen   = 0;
  int cfg_writes   = 0;
  int fails        = 0;

  always #5 clk = ~clk;

  ir_pulse_distance_transmitter_unit #(.BIT_COUNT(FRAME_BITS)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_command_word  (in_command_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ir_level     (out_ir_level),
    .out_busy_res     (out_busy_res),
    .out_frame_done   (out_frame_done),
    .out_send_dropped (out_send_dropped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic int eff_ticks(input logic [TICK_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic logic span_done(input logic [TICK_W-1:0] limit);
    if (int'(tx_ticks) + 1 >= int'(limit)) begin
      tx_ticks = '0;
      return 1'b1;
    end
    tx_ticks = tx_ticks + 1'b1;
    return 1'b0;
  endfunction

  function automatic logic mark_done(input logic [TICK_W-1:0] limit);
    tx_pin = ~tx_pin;
    if (span_done(limit)) begin
      tx_pin = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic apply_word(input logic is_send, input logic [31:0] w);
    ir_result_t r;
    logic cur_bit;
    r = '0;
    cur_bit = 1'b0;
    if (tx_bits_left != 0 && tx_bits_left <= 32)
      cur_bit = tx_shift[tx_bits_left - 1'b1];
    if (is_send) begin
      if (tx_phase != irpdt_pkg::PH_IDLE) begin
        r.dropped = 1'b1;
      end else begin
        tx_shift     = w;
        tx_bits_left = 7'(FRAME_BITS);
        tx_ticks     = '0;
        tx_pin       = 1'b0;
        tx_phase     = irpdt_pkg::PH_START_MARK;
      end
    end else begin
      case (tx_phase)
        irpdt_pkg::PH_START_MARK: begin
          if (mark_done(tx_cfg.start_mark)) tx_phase = irpdt_pkg::PH_START_SPACE;
        end
        irpdt_pkg::PH_START_SPACE: begin
          if (span_done(tx_cfg.start_space))
            tx_phase = (tx_bits_left == 0) ? irpdt_pkg::PH_STOP_MARK : irpdt_pkg::PH_BIT_MARK;
        end
        irpdt_pkg::PH_BIT_MARK: begin
          if (mark_done(tx_cfg.bit_mark)) tx_phase = irpdt_pkg::PH_BIT_SPACE;
        end
        irpdt_pkg::PH_BIT_SPACE: begin
          if (span_done(cur_bit ? tx_cfg.one_space : tx_cfg.zero_space)) begin
            if (tx_bits_left != 0) tx_bits_left = tx_bits_left - 1'b1;
            tx_phase = (tx_bits_left == 0) ? irpdt_pkg::PH_STOP_MARK : irpdt_pkg::PH_BIT_MARK;
          end
        end
        irpdt_pkg::PH_STOP_MARK: begin
          if (mark_done(tx_cfg.bit_mark)) tx_phase = irpdt_pkg::PH_STOP_SPACE;
        end
        irpdt_pkg::PH_STOP_SPACE: begin
          if (span_done(tx_cfg.zero_space)) begin
            tx_phase = irpdt_pkg::PH_IDLE;
            r.done   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.ir_level = tx_pin;
    r.busy     = (tx_phase != irpdt_pkg::PH_IDLE);
    expected_results.push_back(r);
  endtask

  task automatic queue_item(input logic is_send, input logic [31:0] w);
    pending_words.push_back(irpdt_pkg::item_t'{is_send: is_send, word: w});
    queued_count++;
  endtask

  // send plus exactly enough ticks to finish the frame, with stray sends mixed in
  task automatic queue_frame(input logic [31:0] w, input int noise_pct);
    int n;
    n = eff_ticks(tx_cfg.start_mark) + eff_ticks(tx_cfg.start_space)
      + eff_ticks(tx_cfg.bit_mark) + eff_ticks(tx_cfg.zero_space);
    for (int i = 0; i < FRAME_BITS; i++)
      n += eff_ticks(tx_cfg.bit_mark)
         + eff_ticks(w[i] ? tx_cfg.one_space : tx_cfg.zero_space);
    queue_item(1'b1, w);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) queue_item(1'b1, $urandom);
      queue_item(1'b0, $urandom);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      irpdt_pkg::CFG_START_MARK:  tx_cfg.start_mark  = val;
      irpdt_pkg::CFG_START_SPACE: tx_cfg.start_space = val;
      irpdt_pkg::CFG_BIT_MARK:    tx_cfg.bit_mark    = val;
      irpdt_pkg::CFG_ZERO_SPACE:  tx_cfg.zero_space  = val;
      irpdt_pkg::CFG_ONE_SPACE:   tx_cfg.one_space   = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic settle();
    while (!(pending_words.size() == 0 && !in_valid && expected_results.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_timing(input logic [TICK_W-1:0] sm, input logic [TICK_W-1:0] ss,
                                input logic [TICK_W-1:0] bm, input logic [TICK_W-1:0] zs,
                                input logic [TICK_W-1:0] os);
    settle();
    cfg_write(irpdt_pkg::CFG_START_MARK, sm);
    cfg_write(irpdt_pkg::CFG_START_SPACE, ss);
    cfg_write(irpdt_pkg::CFG_BIT_MARK, bm);
    cfg_write(irpdt_pkg::CFG_ZERO_SPACE, zs);
    cfg_write(irpdt_pkg::CFG_ONE_SPACE, os);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] rand_ticks();
    case ($urandom_range(19))
      0:       return '0;
      1, 2, 3: return TICK_W'($urandom_range(5, 24));
      default: return TICK_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    int b;
    b = $urandom_range(31);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << b;
      3:       return ~(32'd1 << b);
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of words separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    irpdt_pkg::item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_word(in_req_type, in_command_word);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= nxt.is_send;
          in_command_word <= nxt.word;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off
  int rx_cycle  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    logic stall_next;
    rx_cycle++;
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case ((rx_cycle / 101) % 4)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(1) == 1);
        2:       stall_next = ($urandom_range(9) < 8);
        default: stall_next = ((rx_cycle % 7) < 3);
      endcase
    end
    out_stall <= stall_next;
  end

  function automatic void check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    ir_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = expected_results.pop_front();
        check_field("ir_level", want.ir_level, out_ir_level);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("frame_done", want.done, out_frame_done);
        check_field("send_dropped", want.dropped, out_send_dropped);
        if (want.done) frames_done++;
        if (want.dropped) drops_seen++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[ir_pulse_distance_transmitter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int nf;
    tx_cfg       = '{start_mark: irpdt_pkg::RST_START_MARK,
                     start_space: irpdt_pkg::RST_START_SPACE,
                     bit_mark: irpdt_pkg::RST_BIT_MARK,
                     zero_space: irpdt_pkg::RST_ZERO_SPACE,
                     one_space: irpdt_pkg::RST_ONE_SPACE};
    tx_phase     = irpdt_pkg::PH_IDLE;
    tx_ticks     = '0;
    tx_shift     = '0;
    tx_bits_left = '0;
    tx_pin       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: idle ticks, the whole default start mark, a send while busy
    queue_item(1'b0, 32'hFFFF_FFFF);
    queue_item(1'b0, 32'h0000_0000);
    queue_item(1'b1, 32'h8000_0001);
    for (int i = 0; i < int'(irpdt_pkg::RST_START_MARK) + 8; i++) begin
      if ($urandom_range(99) < 1) queue_item(1'b1, $urandom);
      queue_item(1'b0, $urandom);
    end
    queue_item(1'b1, 32'hFFFF_FFFF);

    // shortest timing mid-frame, zero bit mark acting as one, unused index
    settle();
    cfg_write(irpdt_pkg::CFG_START_MARK, TICKS_MIN);
    cfg_write(irpdt_pkg::CFG_START_SPACE, TICKS_MIN);
    cfg_write(irpdt_pkg::CFG_BIT_MARK, '0);
    cfg_write(irpdt_pkg::CFG_ZERO_SPACE, TICKS_MIN);
    cfg_write(irpdt_pkg::CFG_ONE_SPACE, TICKS_MIN);
    cfg_write(CFG_UNUSED, TICKS_MAX);
    cfg_valid <= 1'b0;
    // every span now ends on its first tick
    for (int i = 0; i < 2 * FRAME_BITS + 3; i++) queue_item(1'b0, $urandom);
    queue_frame(32'hFFFF_FFFF, 5);
    queue_frame(32'h0000_0000, 5);

    rand_start = queued_count;
    while (queued_count < rand_start + RANDOM_ITEMS) begin
      program_timing(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) begin
        repeat ($urandom_range(0, 3)) queue_item(1'b0, $urandom);
        queue_frame(rand_word(), $urandom_range(0, 8));
      end
    end

    settle();
    repeat (12) @(posedge clk);
    $display("%0d result words checked: %0d frames, %0d dropped sends, %0d register writes",
             results_seen, frames_done, drops_seen, cfg_writes);
    if (fails == 0)
      $display("[ir_pulse_distance_transmitter_unit] OK");
    else
      $display("[ir_pulse_distance_transmitter_unit] ERROR");
    $finish;
  end

endmodule
